[sv/fba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// fba_pkg: shared constants, codes, types and helpers for the free block allocator.
// Depends on nothing; every other source file but fba_ram imports it.

package fba_pkg;

   // pool geometry
   localparam int NUM_BLOCKS = 8192;
   localparam int ADDR_W     = $clog2(NUM_BLOCKS);

   // fixed field widths
   localparam int IDX_W = 13;
   localparam int CNT_W = 14;

   localparam logic [CNT_W-1:0] NUM_BLOCKS_CNT = CNT_W'(NUM_BLOCKS);
   localparam logic [IDX_W:0]   BLK_LIMIT      = (IDX_W+1)'(NUM_BLOCKS);
   localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(NUM_BLOCKS - 1);

   // response buffer depth
   localparam int OUT_DEPTH = 3;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_OCC_W = $clog2(OUT_DEPTH + 1);

   // request function codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_REJECT = 2'd2
   } fba_status_type;

   typedef struct packed {
      logic [IDX_W-1:0] granted_index;
      fba_status_type   status;
      logic [CNT_W-1:0] free_count;
   } fba_result_type;

   function automatic logic [ADDR_W-1:0] wrap_next(input logic [ADDR_W-1:0] p);
      return (p == LAST_ADDR) ? '0 : p + 1'b1;
   endfunction

endpackage

`default_nettype wire

[sv/fba_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// fba_req_if: request channel (valid/ready plus func and block index).
// Depends on fba_pkg for the field widths.

interface fba_req_if import fba_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             func;
   logic [IDX_W-1:0] block_index;

   modport source (output valid, output func, output block_index, input ready);
   modport sink   (input valid, input func, input block_index, output ready);
endinterface

`default_nettype wire

[sv/fba_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// fba_rsp_if: response channel (valid/ready plus grant, status and free count).
// Depends on fba_pkg for the field widths.

interface fba_rsp_if import fba_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] granted_index;
   logic [1:0]       status;
   logic [CNT_W-1:0] free_count;

   modport source (output valid, output granted_index, output status,
                   output free_count, input ready);
   modport sink   (input valid, input granted_index, input status,
                   input free_count, output ready);
endinterface

`default_nettype wire

[sv/fifo_free_block_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Free block allocator: FIFO of free block indices plus a free bitmap in RAM.
// A taken request is registered in the core stage, then in the response buffer.
// Throughput: one request per cycle while no sweep runs and the buffer has space,
// set by the single core-stage pass (each RAM read and written at most once).
// Reset: synchronous; then a clearing sweep over all NUM_BLOCKS (8192) slots loads
// the queue with 0..N-1 and marks every block free, with req_ch.ready low.

module fifo_free_block_allocator import fba_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   fba_req_if.sink   req_ch,
   fba_rsp_if.source rsp_ch
);

   // core stage result, registered in the response buffer
   logic           res_valid;
   fba_result_type res_data;
   logic           space_ok;

   // Core: request register, RAM reads issued at accept, decision and
   // RAM writes in the following cycle. Same-cycle write/read collisions
   // on either RAM are covered by a one-entry bypass.
   fba_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .space_ok  (space_ok),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   // Response buffer: three entries so a stalled sink never loses a
   // response already committed in the core stage.
   fba_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .space_ok  (space_ok),
      .rsp       (rsp_ch)
   );

endmodule

`default_nettype wire

[sv/fba_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// fba_ram: generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.

module fba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/fba_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// fba_core: request register, queue and bitmap RAMs, pointers, free count,
// write-to-read bypass and the post-reset clearing sweep. Uses fba_pkg, fba_req_if, fba_ram.

module fba_core import fba_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   fba_req_if.sink        req,
   input  logic           space_ok,
   output logic           res_valid,
   output fba_result_type res_data
);

   // clearing sweep
   logic              clear_busy_ff, clear_busy_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;

   // request stage
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_func_ff;
   logic [IDX_W-1:0]  s1_blk_ff;

   // queue pointers and count
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // bypass of the write that lands in the same cycle as a read
   logic              qbyp_hit_ff, qbyp_hit_in;
   logic [ADDR_W-1:0] qbyp_data_ff;
   logic              mbyp_hit_ff, mbyp_hit_in;
   logic              mbyp_data_ff;

   logic              accept;
   logic              q_we, m_we;
   logic [ADDR_W-1:0] q_waddr, q_wdata, q_rdata, q_data, m_waddr, m_raddr;
   logic              m_wdata, m_rdata, m_free;
   logic [ADDR_W-1:0] blk_addr;
   logic              blk_in_range;
   logic              do_pop, do_push;

   assign req.ready = !clear_busy_ff && space_ok;
   assign accept    = req.valid && req.ready;

   assign q_data       = qbyp_hit_ff ? qbyp_data_ff : q_rdata;
   assign m_free       = mbyp_hit_ff ? mbyp_data_ff : m_rdata;
   assign blk_addr     = s1_blk_ff[ADDR_W-1:0];
   assign blk_in_range = {1'b0, s1_blk_ff} < BLK_LIMIT;
   assign m_raddr      = req.block_index[ADDR_W-1:0];

   assign do_pop  = s1_valid_ff && (s1_func_ff == FUNC_ALLOC) && (count_ff != '0);
   assign do_push = s1_valid_ff && (s1_func_ff == FUNC_FREE) && blk_in_range &&
                    !m_free && (count_ff < NUM_BLOCKS_CNT);

   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = wrap_next(clear_addr_ff);
         if (clear_addr_ff == LAST_ADDR) begin
            clear_busy_in = 1'b0;
         end
      end

      head_in  = do_pop ? wrap_next(head_ff) : head_ff;
      tail_in  = do_push ? wrap_next(tail_ff) : tail_ff;
      count_in = count_ff;
      if (do_pop) begin
         count_in = count_ff - 1'b1;
      end else if (do_push) begin
         count_in = count_ff + 1'b1;
      end

      // queue write: sweep loads slot i with i, free appends at the tail
      if (clear_busy_ff) begin
         q_we    = 1'b1;
         q_waddr = clear_addr_ff;
         q_wdata = clear_addr_ff;
      end else begin
         q_we    = do_push;
         q_waddr = tail_ff;
         q_wdata = blk_addr;
      end

      // bitmap write: 1 means free
      if (clear_busy_ff) begin
         m_we    = 1'b1;
         m_waddr = clear_addr_ff;
         m_wdata = 1'b1;
      end else if (do_pop) begin
         m_we    = 1'b1;
         m_waddr = q_data;
         m_wdata = 1'b0;
      end else begin
         m_we    = do_push;
         m_waddr = blk_addr;
         m_wdata = 1'b1;
      end

      qbyp_hit_in = q_we && (q_waddr == head_in);
      mbyp_hit_in = m_we && (m_waddr == m_raddr);
      s1_valid_in = accept;

      res_valid              = s1_valid_ff;
      res_data.granted_index = do_pop ? IDX_W'(q_data) : '0;
      res_data.free_count    = count_in;
      if (s1_func_ff == FUNC_ALLOC) begin
         res_data.status = do_pop ? ST_OK : ST_EMPTY;
      end else begin
         res_data.status = do_push ? ST_OK : ST_REJECT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= NUM_BLOCKS_CNT;
         qbyp_hit_ff   <= 1'b0;
         mbyp_hit_ff   <= 1'b0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= s1_valid_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         qbyp_hit_ff   <= qbyp_hit_in;
         mbyp_hit_ff   <= mbyp_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      qbyp_data_ff <= q_wdata;
      mbyp_data_ff <= m_wdata;
      if (accept) begin
         s1_func_ff <= req.func;
         s1_blk_ff  <= req.block_index;
      end
   end

   fba_ram #(.WIDTH(ADDR_W), .DEPTH(NUM_BLOCKS)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (head_in),
      .rd_data (q_rdata)
   );

   fba_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_map_ram (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (m_waddr),
      .wr_data (m_wdata),
      .rd_addr (m_raddr),
      .rd_data (m_rdata)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NUM_BLOCKS_CNT)
      else $error("free count above pool size");

   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> !accept)
      else $error("request taken during clearing sweep");

   a_pop_decrements: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> count_ff == $past(count_ff) - 1'b1)
      else $error("allocate did not decrement free count");

   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      (!do_pop && !do_push) |=> $stable(count_ff) && $stable(head_ff) && $stable(tail_ff))
      else $error("queue state moved without pop or push");

   a_pop_push_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(do_pop && do_push) && !(clear_busy_ff && s1_valid_ff))
      else $error("conflicting queue operations");

endmodule

`default_nettype wire

[sv/fba_rsp_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// fba_rsp_fifo: three-entry response buffer driving the response channel, with
// a credit signal back to the request stage. Uses fba_pkg, fba_rsp_if.

module fba_rsp_fifo import fba_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  fba_result_type push_data,
   output logic           space_ok,
   fba_rsp_if.source      rsp
);

   fba_result_type       entry_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_OCC_W-1:0] occ_ff, occ_in;
   logic                 pop;

   localparam logic [OUT_PTR_W-1:0] LAST_PTR = OUT_PTR_W'(OUT_DEPTH - 1);
   localparam logic [OUT_OCC_W:0]   SPACE_LIMIT = (OUT_OCC_W+1)'(OUT_DEPTH - 1);

   assign pop       = rsp.valid && rsp.ready;
   assign rsp.valid = occ_ff != '0;
   assign rsp.granted_index = entry_ff[rd_ptr_ff].granted_index;
   assign rsp.status        = entry_ff[rd_ptr_ff].status;
   assign rsp.free_count    = entry_ff[rd_ptr_ff].free_count;

   // a request in the core stage already holds a slot
   assign space_ok = ({1'b0, occ_ff} + (OUT_OCC_W+1)'(push)) <= SPACE_LIMIT;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in    = occ_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         occ_in = occ_ff + 1'b1;
      end else if (pop && !push) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> occ_ff != OUT_OCC_W'(OUT_DEPTH))
      else $error("response buffer overflow");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OUT_OCC_W'(OUT_DEPTH))
      else $error("response buffer occupancy out of range");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> occ_ff == $past(occ_ff) + 1'b1)
      else $error("push not counted");

endmodule

`default_nettype wire

[tb/fba_alloc_checker.sv]
`timescale 1ns / 1ps
// fba_alloc_checker: watches the request and response channels of the free block
// allocator, predicts every response and compares it field by field.
// Depends on fba_pkg and on the fba_req_if / fba_rsp_if interfaces.

module fba_alloc_checker import fba_pkg::*; (
   input  logic clock,
   input  logic reset,
   fba_req_if   req_mon,
   fba_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   responses_owed,
   output int   grants_seen,
   output int   empty_seen,
   output int   rejects_seen
);

   // shadow of the pool: free bitmap, ring of free indices, free count
   logic             block_is_free [NUM_BLOCKS];
   logic [IDX_W-1:0] free_ring     [NUM_BLOCKS];
   int               ring_head;
   int               ring_tail;
   int               blocks_free;

   fba_result_type   due_responses [$];
   int               bad_responses;
   int               owed;
   int               n_grant;
   int               n_empty;
   int               n_reject;

   assign mismatch_count = bad_responses;
   assign responses_owed = owed;
   assign grants_seen    = n_grant;
   assign empty_seen     = n_empty;
   assign rejects_seen   = n_reject;

   // applies one request to the shadow pool and returns the response it earns
   function automatic fba_result_type pool_step(input logic f, input logic [IDX_W-1:0] idx);
      fba_result_type r;
      r.granted_index = '0;
      r.status        = ST_OK;
      if (f == FUNC_ALLOC) begin
         if (blocks_free == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.granted_index = free_ring[ring_head];
            block_is_free[r.granted_index] = 1'b0;
            ring_head = (ring_head == NUM_BLOCKS - 1) ? 0 : ring_head + 1;
            blocks_free--;
         end
      end else if (int'(idx) >= NUM_BLOCKS || block_is_free[idx] ||
                   blocks_free >= NUM_BLOCKS) begin
         r.status = ST_REJECT;
      end else begin
         block_is_free[idx]   = 1'b1;
         free_ring[ring_tail] = idx;
         ring_tail = (ring_tail == NUM_BLOCKS - 1) ? 0 : ring_tail + 1;
         blocks_free++;
      end
      r.free_count = CNT_W'(blocks_free);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      fba_result_type want;
      fba_result_type got;
      if (reset) begin
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            block_is_free[i] = 1'b1;
            free_ring[i]     = IDX_W'(i);
         end
         ring_head     = 0;
         ring_tail     = 0;
         blocks_free   = NUM_BLOCKS;
         due_responses.delete();
         bad_responses = 0;
         n_grant       = 0;
         n_empty       = 0;
         n_reject      = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            want = pool_step(req_mon.func, req_mon.block_index);
            case (want.status)
               ST_OK:     if (req_mon.func == FUNC_ALLOC) n_grant++;
               ST_EMPTY:  n_empty++;
               ST_REJECT: n_reject++;
               default:   ;
            endcase
            due_responses.insert(due_responses.size(), want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.granted_index = rsp_mon.granted_index;
            got.status        = fba_status_type'(rsp_mon.status);
            got.free_count    = rsp_mon.free_count;
            if (due_responses.size() == 0) begin
               if (bad_responses < 10)
                  $display("%0t: response with none outstanding: %s %0d status %0d free %0d",
                           $realtime, "grant", got.granted_index, rsp_mon.status,
                           got.free_count);
               bad_responses++;
            end else begin
               want = due_responses[0];
               due_responses.delete(0);
               if (rsp_mon.granted_index !== want.granted_index ||
                   rsp_mon.status !== 2'(want.status) ||
                   rsp_mon.free_count !== want.free_count) begin
                  if (bad_responses < 10)
                     $display({"%0t: mismatch: expected grant %0d status %0d free %0d,",
                               " got grant %0d status %0d free %0d"},
                              $realtime, want.granted_index, 2'(want.status),
                              want.free_count, rsp_mon.granted_index, rsp_mon.status,
                              rsp_mon.free_count);
                  bad_responses++;
               end
            end
         end
      end
      owed = due_responses.size();
   end

endmodule

[tb/fifo_free_block_allocator_tb.sv]
`timescale 1ns / 1ps
// fifo_free_block_allocator_tb: stimulus and verdict for the free block allocator.
// Depends on fba_pkg, the two channel interfaces, the block and fba_alloc_checker.

module fifo_free_block_allocator_tb import fba_pkg::*; ();

   localparam int RANDOM_REQUESTS = 835;
   localparam int TAIL_REQUESTS   = 300;
   localparam int IDLE_PERCENT    = 17;
   // no idling on either side while the request count is in this window
   localparam int CALM_FROM       = 700;
   localparam int CALM_TO         = 1000;
   // long response hold-off, started once this many requests went in
   localparam int HOLD_AT         = 400;
   localparam int HOLD_CYCLES     = 300;

   logic clock;
   logic reset;

   fba_req_if req_ch ();
   fba_rsp_if rsp_ch ();

   int mismatch_count;
   int responses_owed;
   int grants_seen;
   int empty_seen;
   int rejects_seen;

   int requests_taken = 0;
   int issued_allocs  = 0;
   bit held_off       = 1'b0;

   int pick;
   int span;

   fifo_free_block_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   fba_alloc_checker alloc_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .responses_owed (responses_owed),
      .grants_seen    (grants_seen),
      .empty_seen     (empty_seen),
      .rejects_seen   (rejects_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // every request that goes in, counted at the edge that takes it
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) requests_taken++;
   end

   function automatic bit calm_window();
      return requests_taken >= CALM_FROM && requests_taken < CALM_TO;
   endfunction

   function automatic bit take_break();
      return !calm_window() && ($urandom_range(0, 99) < IDLE_PERCENT);
   endfunction

   // Offers one request at the falling edge and holds it until the block takes
   // it. Valid stays high into the next request unless a random gap comes.
   task automatic push_request(input logic f, input logic [IDX_W-1:0] idx);
      while (take_break()) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= f;
      req_ch.block_index <= idx;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // allocate carries a random block index, which the block must ignore
   task automatic ask_alloc();
      issued_allocs++;
      push_request(FUNC_ALLOC, IDX_W'($urandom));
   endtask

   // Response side: random back-pressure, plus one long hold-off so that the
   // response buffer fills and the request side stalls.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && requests_taken >= HOLD_AT) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ch.ready <= !take_break();
      end
   end

   // Hard limit; a correct run, clearing sweep included, needs well under a
   // tenth of this.
   initial begin
      #2_000_000;
      $display("fifo_free_block_allocator test failed");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.func        = FUNC_ALLOC;
      req_ch.block_index = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part ----
      // frees against a full pool are rejected, lowest and highest index
      push_request(FUNC_FREE, IDX_W'(0));
      push_request(FUNC_FREE, IDX_W'(NUM_BLOCKS - 1));
      // first grants come out in ascending order; index field is don't-care
      issued_allocs += 4;
      push_request(FUNC_ALLOC, '1);
      push_request(FUNC_ALLOC, '0);
      push_request(FUNC_ALLOC, IDX_W'(13'h0AAA));
      push_request(FUNC_ALLOC, IDX_W'(13'h1555));
      // good free, then the same block again (double free is rejected)
      push_request(FUNC_FREE, IDX_W'(2));
      push_request(FUNC_FREE, IDX_W'(2));
      push_request(FUNC_FREE, IDX_W'(3));
      ask_alloc();
      // top block was never handed out, so freeing it is rejected
      push_request(FUNC_FREE, IDX_W'(NUM_BLOCKS - 1));
      push_request(FUNC_FREE, IDX_W'(0));
      push_request(FUNC_FREE, IDX_W'(1));
      ask_alloc();
      ask_alloc();

      // ---- random mix: mostly allocates, and frees mostly of blocks handed out so far ----
      for (int k = 0; k < RANDOM_REQUESTS; k++) begin
         pick = $urandom_range(0, 99);
         span = (issued_allocs < NUM_BLOCKS) ? issued_allocs : NUM_BLOCKS - 1;
         if (pick < 55)
            ask_alloc();
         else if (pick < 90)
            push_request(FUNC_FREE, IDX_W'($urandom_range(0, span)));
         else
            push_request(FUNC_FREE, IDX_W'($urandom_range(0, NUM_BLOCKS - 1)));
      end

      // ---- random tail: allocates and frees of any index ----
      for (int k = 0; k < TAIL_REQUESTS; k++) begin
         if ($urandom_range(0, 99) < 60)
            ask_alloc();
         else
            push_request(FUNC_FREE, IDX_W'($urandom_range(0, NUM_BLOCKS - 1)));
      end

      req_ch.valid <= 1'b0;

      // wait for every outstanding response, then keep the clock running so a
      // stray extra response would still be caught
      wait (responses_owed == 0);
      repeat (16) @(posedge clock);

      $display("covered %0d requests: %0d grants, %0d empty-pool allocates, %0d rejected frees",
               requests_taken, grants_seen, empty_seen, rejects_seen);
      $display("double and unallocated frees, random alloc/free mix, one %0d-cycle stall",
               HOLD_CYCLES);
      if (mismatch_count == 0 && responses_owed == 0) begin
         $display("fifo_free_block_allocator test passed");
      end else begin
         $display("fifo_free_block_allocator test failed");
      end
      $finish;
   end

endmodule

[fifo_free_block_allocator.f]
sv/fba_pkg.sv
sv/fba_req_if.sv
sv/fba_rsp_if.sv
sv/fba_ram.sv
sv/fba_core.sv
sv/fba_rsp_fifo.sv
sv/fifo_free_block_allocator.sv
tb/fba_alloc_checker.sv
tb/fifo_free_block_allocator_tb.sv
